>>> rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the polyphonic voice allocator
// Pool sizes, memory layout, result and request structs, small arithmetic.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Pool sizes (each 1..32 voices).
  localparam int POOL_A_VOICES = 6;
  localparam int POOL_B_VOICES = 6;
  localparam int POOL_C_VOICES = 18;

  // Field widths fixed by the item format.
  localparam int VOICE_W    = 5;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int PITCH_W    = 7;
  localparam int OCT_W      = 3;
  localparam int CNT_W      = 8;
  localparam int CODE_W     = 3;
  localparam int SUB_W      = 2;
  localparam int RESV_A_W   = 6;
  localparam int RESV_B_W   = 6;
  localparam int RESV_C_W   = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int MAX_VOICES = 2 ** VOICE_W;

  // Note memory layout: the three pools back to back.
  localparam int A_BASE     = 0;
  localparam int B_BASE     = POOL_A_VOICES;
  localparam int C_BASE     = POOL_A_VOICES + POOL_B_VOICES;
  localparam int NOTE_DEPTH = POOL_A_VOICES + POOL_B_VOICES + POOL_C_VOICES;
  localparam int NOTE_AW    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  // Activity counter memory: one entry per target code.
  localparam int NUM_TGT = 5;
  localparam int CNT_AW  = $clog2(NUM_TGT);

  // Reciprocal constants: x/12 for x < 2**8, x/3 for x < 2**5.
  localparam int DIV12_MUL   = 171;
  localparam int DIV12_SHIFT = 11;
  localparam int MOD3_MUL    = 11;
  localparam int MOD3_SHIFT  = 5;

  // Pitch offsets of pools A and B, note offset and octave bias of pool C.
  localparam int PITCH_OFS_A = 11;
  localparam int PITCH_OFS_B = 45;
  localparam int C_NOTE_OFS  = 5;
  localparam int C_OCT_BIAS  = 2;
  localparam int OCT_MAX     = 7;
  localparam int UNIT_SPLIT  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SELECT    = 3'd0,
    REG_PREFER_ALTERNATE = 3'd1,
    REG_RESERVED_A       = 3'd2,
    REG_RESERVED_B       = 3'd3,
    REG_RESERVED_C       = 3'd4
  } cfg_reg_t;

  typedef enum logic [CODE_W-1:0] {
    SEL_PASS_MAIN = 3'd0,
    SEL_POOL_A    = 3'd1,
    SEL_POOL_B    = 3'd2,
    SEL_POOL_C    = 3'd3,
    SEL_PASS_ALT  = 3'd4
  } sel_t;

  typedef enum logic [CODE_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_PASS_ON   = 3'd1,
    ACT_PASS_OFF  = 3'd2,
    ACT_VOICE_ON  = 3'd3,
    ACT_VOICE_OFF = 3'd4
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    TGT_PASS_MAIN = 3'd0,
    TGT_PASS_ALT  = 3'd1,
    TGT_POOL_A    = 3'd2,
    TGT_POOL_B    = 3'd3,
    TGT_POOL_C    = 3'd4
  } target_t;

  typedef struct packed {
    logic [CODE_W-1:0]   target_select;
    logic                prefer_alternate;
    logic [RESV_A_W-1:0] reserved_a;
    logic [RESV_B_W-1:0] reserved_b;
    logic [RESV_C_W-1:0] reserved_c;
  } cfg_t;

  typedef struct packed {
    action_t              action;
    target_t              target;
    logic [VOICE_W-1:0]   voice;
    logic                 voice_found;
    logic                 second_unit;
    logic [SUB_W-1:0]     sub_voice;
    logic [NOTE_W-1:0]    note;
    logic [VEL_W-1:0]     velocity;
    logic [PITCH_W-1:0]   pitch_index;
    logic [OCT_W-1:0]     octave;
    logic [CNT_W-1:0]     activity_count;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [NOTE_AW-1:0] waddr;
    logic [NOTE_W-1:0]  wdata;
    logic [NOTE_AW-1:0] raddr;
  } note_req_t;

  typedef struct packed {
    logic              we;
    logic [CNT_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [CNT_AW-1:0] raddr;
  } cnt_req_t;

  typedef struct packed {
    logic [3:0] quo;
    logic [3:0] rem;
  } div12_t;

  // Split an 8-bit value (at most 132) into quotient and remainder by 12.
  function automatic div12_t div12(input logic [7:0] s);
    logic [15:0] prod;
    logic [3:0]  q;
    div12_t      res;
    prod    = 16'(s) * 16'(DIV12_MUL);
    q       = 4'(prod >> DIV12_SHIFT);
    res.quo = q;
    res.rem = 4'(s - 8'(q) * 8'(12));
    return res;
  endfunction

  // Voice index modulo three.
  function automatic logic [SUB_W-1:0] mod3(input logic [VOICE_W-1:0] v);
    logic [8:0] prod;
    logic [3:0] q;
    prod = 9'(v) * 9'(MOD3_MUL);
    q    = 4'(prod >> MOD3_SHIFT);
    return SUB_W'(v - 5'(q) * 5'(3));
  endfunction

endpackage

>>> rtl/core/pva_in_if.sv
// ----------------------------------------------------------------------------
// pva_in_if: note event channel
// One beat carries one note-on or note-off event.
// ----------------------------------------------------------------------------
interface pva_in_if;
  logic                         valid;
  logic                         ready;
  logic                         is_on;
  logic [pva_pkg::VOICE_W-1:0]  chan;
  logic [pva_pkg::NOTE_W-1:0]   note;
  logic [pva_pkg::VEL_W-1:0]    velocity;
  logic                         is_beat;

  modport source (output valid, is_on, chan, note, velocity, is_beat, input ready);
  modport sink   (input valid, is_on, chan, note, velocity, is_beat, output ready);
endinterface

>>> rtl/core/pva_out_if.sv
// ----------------------------------------------------------------------------
// pva_out_if: voice command channel
// One beat carries the command that one note event produced.
// ----------------------------------------------------------------------------
interface pva_out_if;
  logic                         valid;
  logic                         ready;
  logic [pva_pkg::CODE_W-1:0]   action;
  logic [pva_pkg::CODE_W-1:0]   target;
  logic [pva_pkg::VOICE_W-1:0]  voice;
  logic                         voice_found;
  logic                         second_unit;
  logic [pva_pkg::SUB_W-1:0]    sub_voice;
  logic [pva_pkg::NOTE_W-1:0]   note_out;
  logic [pva_pkg::VEL_W-1:0]    velocity_out;
  logic [pva_pkg::PITCH_W-1:0]  pitch_index;
  logic [pva_pkg::OCT_W-1:0]    octave;
  logic [pva_pkg::CNT_W-1:0]    activity_count;

  modport source (output valid, action, target, voice, voice_found, second_unit, sub_voice,
                  note_out, velocity_out, pitch_index, octave, activity_count,
                  input ready);
  modport sink   (input valid, action, target, voice, voice_found, second_unit, sub_voice,
                  note_out, velocity_out, pitch_index, octave, activity_count,
                  output ready);
endinterface

>>> rtl/core/pva_cfg_if.sv
// ----------------------------------------------------------------------------
// pva_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface pva_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pva_pkg::CFG_IDX_W-1:0]   index;
  logic [pva_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
module pva_ram #(
  parameter int  DEPTH = 2,
  parameter int  WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pva_cfg_regs.sv
// ----------------------------------------------------------------------------
// pva_cfg_regs: configuration register file
// Take one register write per beat; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module pva_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  pva_cfg_if.sink         cfg_ch,
  output pva_pkg::cfg_t   cfg
);

  pva_pkg::cfg_t cfg_r;
  pva_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pva_pkg::REG_TARGET_SELECT: begin
          cfg_nxt.target_select = cfg_ch.data[pva_pkg::CODE_W-1:0];
        end
        pva_pkg::REG_PREFER_ALTERNATE: begin
          cfg_nxt.prefer_alternate = cfg_ch.data[0];
        end
        pva_pkg::REG_RESERVED_A: begin
          cfg_nxt.reserved_a = cfg_ch.data[pva_pkg::RESV_A_W-1:0];
        end
        pva_pkg::REG_RESERVED_B: begin
          cfg_nxt.reserved_b = cfg_ch.data[pva_pkg::RESV_B_W-1:0];
        end
        pva_pkg::REG_RESERVED_C: begin
          cfg_nxt.reserved_c = cfg_ch.data[pva_pkg::RESV_C_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl: event sequencer of the voice allocator
// Decode an event, search the note memory, update the counter memory and
// hand the finished command to the output register.
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  pva_in_if.sink                         in_ch,
  input  pva_pkg::cfg_t                  cfg,
  output pva_pkg::note_req_t             note_req,
  input  logic [pva_pkg::NOTE_W-1:0]     note_rdata,
  output pva_pkg::cnt_req_t              cnt_req,
  input  logic [pva_pkg::CNT_W-1:0]      cnt_rdata,
  output pva_pkg::result_t               out_res,
  output logic                           out_valid,
  input  logic                           out_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CNT,
    S_UPD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [pva_pkg::NOTE_DEPTH-1:0] busy_r, busy_nxt;
  logic [pva_pkg::NUM_TGT-1:0]    cnt_vld_r, cnt_vld_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;

  // Event payload
  logic                           is_on_r, is_on_nxt;
  logic [pva_pkg::VOICE_W-1:0]    chan_r, chan_nxt;
  logic [pva_pkg::NOTE_W-1:0]     note_r, note_nxt;
  logic [pva_pkg::VEL_W-1:0]      vel_r, vel_nxt;
  logic [pva_pkg::CODE_W-1:0]     sel_r, sel_nxt;
  logic                           is_pool_r, is_pool_nxt;
  pva_pkg::target_t               cidx_r, cidx_nxt;
  pva_pkg::target_t               tgt_r, tgt_nxt;
  logic [pva_pkg::NOTE_AW-1:0]    base_r, base_nxt;
  logic [pva_pkg::VOICE_W-1:0]    last_r, last_nxt;
  logic [pva_pkg::VOICE_W-1:0]    v_r, v_nxt;
  logic                           found_r, found_nxt;
  logic [pva_pkg::VOICE_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [pva_pkg::VOICE_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  pva_pkg::result_t               res_r, res_nxt;
  pva_pkg::result_t               out_r, out_nxt;

  // Pool lookup
  logic [pva_pkg::MAX_VOICES-1:0] busy_a, busy_b, busy_c;
  logic [pva_pkg::MAX_VOICES-1:0] sel_avail;
  logic [pva_pkg::NOTE_AW-1:0]    sel_base;
  logic [pva_pkg::VOICE_W-1:0]    sel_last;
  logic                           free_found;
  logic [pva_pkg::VOICE_W-1:0]    free_idx;

  // Datapath
  logic                           in_ready;
  logic                           ignore;
  logic [pva_pkg::NOTE_AW-1:0]    scan_addr, cmp_addr, voice_addr;
  logic                           hit;
  logic [pva_pkg::CNT_W-1:0]      cnt_old, cnt_new;
  pva_pkg::div12_t                c_div;
  logic [3:0]                     c_oct;

  assign in_ch.ready = in_ready;
  assign out_valid   = out_valid_r;
  assign out_res     = out_r;

  // Busy view of each pool, voices beyond the pool read as busy.
  always_comb begin
    busy_a = '1;
    busy_b = '1;
    busy_c = '1;
    for (int i = 0; i < pva_pkg::POOL_A_VOICES; i++) begin
      busy_a[i] = busy_r[pva_pkg::NOTE_AW'(pva_pkg::A_BASE + i)];
    end
    for (int i = 0; i < pva_pkg::POOL_B_VOICES; i++) begin
      busy_b[i] = busy_r[pva_pkg::NOTE_AW'(pva_pkg::B_BASE + i)];
    end
    for (int i = 0; i < pva_pkg::POOL_C_VOICES; i++) begin
      busy_c[i] = busy_r[pva_pkg::NOTE_AW'(pva_pkg::C_BASE + i)];
    end

    unique case (cfg.target_select)
      pva_pkg::SEL_POOL_B: begin
        sel_base  = pva_pkg::NOTE_AW'(pva_pkg::B_BASE);
        sel_last  = pva_pkg::VOICE_W'(pva_pkg::POOL_B_VOICES - 1);
        sel_avail = ~busy_b & ~pva_pkg::MAX_VOICES'(cfg.reserved_b);
      end
      pva_pkg::SEL_POOL_C: begin
        sel_base  = pva_pkg::NOTE_AW'(pva_pkg::C_BASE);
        sel_last  = pva_pkg::VOICE_W'(pva_pkg::POOL_C_VOICES - 1);
        sel_avail = ~busy_c & ~pva_pkg::MAX_VOICES'(cfg.reserved_c);
      end
      default: begin
        sel_base  = pva_pkg::NOTE_AW'(pva_pkg::A_BASE);
        sel_last  = pva_pkg::VOICE_W'(pva_pkg::POOL_A_VOICES - 1);
        sel_avail = ~busy_a & ~pva_pkg::MAX_VOICES'(cfg.reserved_a);
      end
    endcase

    // Lowest available voice wins.
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pva_pkg::MAX_VOICES - 1; i >= 0; i--) begin
      if (sel_avail[i]) begin
        free_found = 1'b1;
        free_idx   = pva_pkg::VOICE_W'(i);
      end
    end
  end

  assign scan_addr  = pva_pkg::NOTE_AW'(32'(base_r) + 32'(scan_idx_r));
  assign cmp_addr   = pva_pkg::NOTE_AW'(32'(base_r) + 32'(cmp_idx_r));
  assign voice_addr = pva_pkg::NOTE_AW'(32'(base_r) + 32'(v_r));
  assign hit        = busy_r[cmp_addr] && (note_rdata == note_r);

  assign cnt_old = cnt_vld_r[cidx_r] ? cnt_rdata : '0;
  assign cnt_new = is_on_r ? pva_pkg::CNT_W'(cnt_old + 1'b1)
                 : ((cnt_old != '0) ? pva_pkg::CNT_W'(cnt_old - 1'b1) : '0);

  assign c_div = pva_pkg::div12(8'(note_r) + 8'(pva_pkg::C_NOTE_OFS));
  assign c_oct = (c_div.quo >= 4'(pva_pkg::C_OCT_BIAS))
               ? 4'(c_div.quo - 4'(pva_pkg::C_OCT_BIAS)) : '0;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    cnt_vld_nxt   = cnt_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmp_vld_nxt   = cmp_vld_r;
    is_on_nxt     = is_on_r;
    chan_nxt      = chan_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    sel_nxt       = sel_r;
    is_pool_nxt   = is_pool_r;
    cidx_nxt      = cidx_r;
    tgt_nxt       = tgt_r;
    base_nxt      = base_r;
    last_nxt      = last_r;
    v_nxt         = v_r;
    found_nxt     = found_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    in_ready      = 1'b0;
    ignore        = 1'b0;

    note_req.we    = 1'b0;
    note_req.waddr = voice_addr;
    note_req.wdata = note_r;
    note_req.raddr = scan_addr;
    cnt_req.we     = 1'b0;
    cnt_req.waddr  = pva_pkg::CNT_AW'(cidx_r);
    cnt_req.wdata  = cnt_new;
    cnt_req.raddr  = pva_pkg::CNT_AW'(cidx_r);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          is_on_nxt = in_ch.is_on;
          chan_nxt  = in_ch.chan;
          note_nxt  = in_ch.note;
          vel_nxt   = in_ch.velocity;
          sel_nxt   = cfg.target_select;
          base_nxt  = sel_base;
          last_nxt  = sel_last;
          state_nxt = S_CNT;
          unique case (cfg.target_select) inside
            pva_pkg::SEL_PASS_MAIN, pva_pkg::SEL_PASS_ALT: begin
              is_pool_nxt = 1'b0;
              cidx_nxt    = cfg.prefer_alternate ? pva_pkg::TGT_PASS_ALT
                                                 : pva_pkg::TGT_PASS_MAIN;
              tgt_nxt     = (cfg.prefer_alternate ||
                             cfg.target_select == pva_pkg::SEL_PASS_ALT)
                          ? pva_pkg::TGT_PASS_ALT : pva_pkg::TGT_PASS_MAIN;
              v_nxt       = in_ch.chan;
              found_nxt   = 1'b1;
            end
            pva_pkg::SEL_POOL_A, pva_pkg::SEL_POOL_B, pva_pkg::SEL_POOL_C: begin
              is_pool_nxt = 1'b1;
              cidx_nxt    = pva_pkg::target_t'(cfg.target_select + 3'd1);
              tgt_nxt     = pva_pkg::target_t'(cfg.target_select + 3'd1);
              v_nxt       = in_ch.chan;
              found_nxt   = (in_ch.chan <= sel_last);
              if (in_ch.is_on) begin
                if (!in_ch.is_beat) begin
                  v_nxt     = free_idx;
                  found_nxt = free_found;
                end
              end else if (!(in_ch.is_beat && cfg.target_select == pva_pkg::SEL_POOL_A)) begin
                // Search the pool for the note, one entry a cycle.
                scan_idx_nxt = '0;
                cmp_vld_nxt  = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              ignore = 1'b1;
            end
          endcase
          if (in_ch.is_on && in_ch.note == '0) begin
            ignore = 1'b1;
          end
          if (ignore) begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end
        end
      end

      S_SCAN: begin
        // Read entry scan_idx, compare the entry read in the previous cycle.
        if (scan_idx_r != last_r) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_idx_r;
        if (cmp_vld_r) begin
          if (hit) begin
            v_nxt     = cmp_idx_r;
            found_nxt = 1'b1;
            state_nxt = S_CNT;
          end else if (cmp_idx_r == last_r) begin
            found_nxt = 1'b0;
            state_nxt = S_CNT;
          end
        end
      end

      S_CNT: begin
        state_nxt = S_UPD;
      end

      S_UPD: begin
        cnt_req.we           = 1'b1;
        cnt_vld_nxt[cidx_r]  = 1'b1;
        if (is_pool_r && found_r) begin
          if (is_on_r) begin
            note_req.we          = 1'b1;
            busy_nxt[voice_addr] = 1'b1;
          end else begin
            busy_nxt[voice_addr] = 1'b0;
          end
        end

        res_nxt = '0;
        if (is_pool_r) begin
          res_nxt.action = is_on_r ? pva_pkg::ACT_VOICE_ON : pva_pkg::ACT_VOICE_OFF;
        end else begin
          res_nxt.action = is_on_r ? pva_pkg::ACT_PASS_ON : pva_pkg::ACT_PASS_OFF;
        end
        res_nxt.target         = tgt_r;
        res_nxt.voice          = found_r ? v_r : '0;
        res_nxt.voice_found    = found_r;
        res_nxt.note           = note_r;
        res_nxt.velocity       = vel_r;
        res_nxt.activity_count = cnt_new;
        if (is_pool_r && found_r && sel_r != pva_pkg::SEL_POOL_C) begin
          res_nxt.second_unit = (v_r > pva_pkg::VOICE_W'(pva_pkg::UNIT_SPLIT));
          res_nxt.sub_voice   = pva_pkg::mod3(v_r);
        end
        unique case (sel_r)
          pva_pkg::SEL_POOL_A: begin
            res_nxt.pitch_index = (note_r > pva_pkg::NOTE_W'(pva_pkg::PITCH_OFS_A))
                                ? pva_pkg::PITCH_W'(note_r - pva_pkg::NOTE_W'(pva_pkg::PITCH_OFS_A))
                                : '0;
          end
          pva_pkg::SEL_POOL_B: begin
            res_nxt.pitch_index = (note_r > pva_pkg::NOTE_W'(pva_pkg::PITCH_OFS_B))
                                ? pva_pkg::PITCH_W'(note_r - pva_pkg::NOTE_W'(pva_pkg::PITCH_OFS_B))
                                : '0;
          end
          pva_pkg::SEL_POOL_C: begin
            res_nxt.pitch_index = pva_pkg::PITCH_W'(c_div.rem);
            res_nxt.octave      = (c_oct > 4'(pva_pkg::OCT_MAX))
                                ? pva_pkg::OCT_W'(pva_pkg::OCT_MAX) : pva_pkg::OCT_W'(c_oct);
          end
          default: begin
          end
        endcase
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
    is_on_r    <= is_on_nxt;
    chan_r     <= chan_nxt;
    note_r     <= note_nxt;
    vel_r      <= vel_nxt;
    sel_r      <= sel_nxt;
    is_pool_r  <= is_pool_nxt;
    cidx_r     <= cidx_nxt;
    tgt_r      <= tgt_nxt;
    base_r     <= base_nxt;
    last_r     <= last_nxt;
    v_r        <= v_nxt;
    found_r    <= found_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  a_note_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    note_req.we |-> state_r == S_UPD)
    else $error("note memory written outside the update step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after taking an event");

  a_scan_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && cmp_vld_r |-> cmp_idx_r <= last_r)
    else $error("note search ran past the end of the pool");

  a_one_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_req.we |=> !cnt_req.we)
    else $error("activity counter written twice for one event");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && (!out_valid_r || out_ready) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished command not moved to the output register");

endmodule

>>> rtl/core/poly_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_top: polyphonic voice allocator, first free voice
// Turns note events into voice commands for pass-through or pooled voices.
//
// Channels:
//   in_ch  - one beat per note event (is_on, chan, note, velocity, is_beat).
//   out_ch - one beat per event: the voice command it produced.
//   cfg_ch - register writes (target select, alternate preference, reserved
//            voice masks); always ready, write only while no event is open.
// Timing: one event at a time; the next is taken once the last command is in
//   the output register. A note-on or pass-through event steps from idle
//   through the count read and the update state to the hand-off; an ignored
//   event or an unused target select goes from idle straight to the hand-off.
//   A note-off that searches a pool reads one voice a cycle until a voice
//   holds the note or the pool ends (single note memory port).
// Reset: synchronous, active low; all voices free, all activity counts zero,
//   configuration registers zero. No clearing pass: busy and count-valid
//   flags live in flip-flops beside the memories.
// Stall: a finished command waits in the output register; the next event is
//   still taken and worked on, and only its own hand-off waits for the slot.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top (
  input  logic       clk,
  input  logic       rst_n,
  pva_in_if.sink     in_ch,
  pva_out_if.source  out_ch,
  pva_cfg_if.sink    cfg_ch
);

  pva_pkg::cfg_t                  cfg;
  pva_pkg::note_req_t             note_req;
  pva_pkg::cnt_req_t              cnt_req;
  logic [pva_pkg::NOTE_W-1:0]     note_rdata;
  logic [pva_pkg::CNT_W-1:0]      cnt_rdata;
  pva_pkg::result_t               res;

  // Register file
  pva_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Note memory: the notes held by all pool voices, pools back to back.
  pva_ram #(
    .DEPTH (pva_pkg::NOTE_DEPTH),
    .WIDTH (pva_pkg::NOTE_W)
  ) u_note_ram (
    .clk   (clk),
    .we    (note_req.we),
    .waddr (note_req.waddr),
    .wdata (note_req.wdata),
    .raddr (note_req.raddr),
    .rdata (note_rdata)
  );

  // Activity counter memory, addressed by target code.
  pva_ram #(
    .DEPTH (pva_pkg::NUM_TGT),
    .WIDTH (pva_pkg::CNT_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_req.we),
    .waddr (cnt_req.waddr),
    .wdata (cnt_req.wdata),
    .raddr (cnt_req.raddr),
    .rdata (cnt_rdata)
  );

  // Sequencer with the output register.
  pva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .note_req   (note_req),
    .note_rdata (note_rdata),
    .cnt_req    (cnt_req),
    .cnt_rdata  (cnt_rdata),
    .out_res    (res),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready)
  );

  // Unpack the command onto the result channel.
  assign out_ch.action         = res.action;
  assign out_ch.target         = res.target;
  assign out_ch.voice          = res.voice;
  assign out_ch.voice_found    = res.voice_found;
  assign out_ch.second_unit    = res.second_unit;
  assign out_ch.sub_voice      = res.sub_voice;
  assign out_ch.note_out       = res.note;
  assign out_ch.velocity_out   = res.velocity;
  assign out_ch.pitch_index    = res.pitch_index;
  assign out_ch.octave         = res.octave;
  assign out_ch.activity_count = res.activity_count;

endmodule
